// ===== rtl/nmea_sentence_checksum_checker_unit_assert.svh =====
// ---------------------------------------------------------------------------
// NMEA checksum checker assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_CHECKER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication
`define NSCC_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define NSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nscc_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum checker package
// Shared constants, record types and helper functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nscc_pkg;

	// Frame storage capacity; the block stores up to FRAME_CAPACITY-1 characters
	localparam int FRAME_CAPACITY = 128;
	localparam logic [7:0] STORE_LIMIT = 8'(FRAME_CAPACITY - 1);
	localparam int HEADER_LEN = 5;

	// Character codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// Outcome codes
	localparam logic [1:0] OUT_NO_STAR  = 2'd0;
	localparam logic [1:0] OUT_MISMATCH = 2'd1;
	localparam logic [1:0] OUT_MATCH    = 2'd2;

	// Sentence kind codes
	localparam logic [2:0] KIND_UNKNOWN = 3'd0;
	localparam int NUM_KINDS = 7;

	// Close-record queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Header: element 0 is the first stored character
	typedef logic [0:HEADER_LEN-1][7:0] header_t;

	localparam header_t KIND_NAMES [NUM_KINDS] = '{
		"GNGGA", "GNRMC", "GNGSA", "GLGSV", "GPGSV", "BDGSV", "GNVTG"
	};

	// Snapshot of a closed sentence handed from front to back
	typedef struct packed {
		logic [7:0]  running_xor;
		header_t     header;
		logic        asterisk_stored;
		logic [7:0]  digit_high;
		logic [7:0]  digit_low;
		logic [31:0] byte_total;
	} close_t;

	// Hex digit value; non-hex codes map to (c - 48) mod 256
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h41 && c <= 8'h46)
			v = c - 8'h37;
		else if (c >= 8'h61 && c <= 8'h66)
			v = c - 8'h57;
		else
			v = c - 8'h30;
		return v;
	endfunction

	// First table entry equal to the header, 1-based; unknown otherwise
	function automatic logic [2:0] classify(input header_t h);
		logic [2:0] k;
		k = KIND_UNKNOWN;
		for (int i = NUM_KINDS - 1; i >= 0; i--) begin
			if (h == KIND_NAMES[i])
				k = 3'(i + 1);
		end
		return k;
	endfunction

endpackage

// ===== rtl/nscc_if.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum checker channel interfaces
// Valid/ready channels for received bytes and for sentence results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Received byte channel
interface nscc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Sentence result channel
interface nscc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [2:0]  sentence_kind;
	logic        accepted;
	logic [7:0]  computed_sum;
	logic [7:0]  received_sum;
	logic [31:0] pass_total;
	logic [31:0] fail_total;
	logic [31:0] byte_total;

	modport source (
		output valid, output outcome, output sentence_kind, output accepted,
		output computed_sum, output received_sum, output pass_total,
		output fail_total, output byte_total, input ready
	);
	modport sink (
		input valid, input outcome, input sentence_kind, input accepted,
		input computed_sum, input received_sum, input pass_total,
		input fail_total, input byte_total, output ready
	);
endinterface

// ===== rtl/nscc_front.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum checker front end
// Takes one byte per cycle while the close-record queue is not full, tracks
// sentence framing, XOR and stored fields, and pushes a close record when a
// line feed ends an open sentence.
`timescale 1ns / 1ps

module nscc_front (
	input  logic            clk,
	input  logic            arst_n,
	nscc_byte_if.sink       rx,
	input  logic            q_full,
	output logic            push,
	output nscc_pkg::close_t push_rec
);
	import nscc_pkg::*;

	logic        in_sentence_q;
	logic        past_star_q;
	logic [7:0]  xor_q;
	logic [7:0]  stored_cnt_q;
	header_t     header_q;
	logic        star_stored_q;
	logic [1:0]  digits_q;
	logic [7:0]  digit_high_q;
	logic [7:0]  digit_low_q;
	logic [31:0] byte_cnt_q;

	logic       take;
	logic [7:0] c;

	assign rx.ready = !q_full;
	assign take     = rx.valid && rx.ready;
	assign c        = rx.rx_byte;

	// Close record leaves with the count that includes the line feed
	assign push = take && in_sentence_q && (c == CH_LF);
	always_comb begin
		push_rec.running_xor     = xor_q;
		push_rec.header          = header_q;
		push_rec.asterisk_stored = star_stored_q;
		push_rec.digit_high      = digit_high_q;
		push_rec.digit_low       = digit_low_q;
		push_rec.byte_total      = byte_cnt_q + 32'd1;
	end

	// Sentence state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			past_star_q   <= 1'b0;
			xor_q         <= '0;
			stored_cnt_q  <= '0;
			header_q      <= '0;
			star_stored_q <= 1'b0;
			digits_q      <= '0;
			digit_high_q  <= '0;
			digit_low_q   <= '0;
			byte_cnt_q    <= '0;
		end else if (take) begin
			byte_cnt_q <= byte_cnt_q + 32'd1;
			if (c == CH_DOLLAR) begin
				in_sentence_q <= 1'b1;
				past_star_q   <= 1'b0;
				xor_q         <= '0;
				stored_cnt_q  <= '0;
				header_q      <= '0;
				star_stored_q <= 1'b0;
				digits_q      <= '0;
				digit_high_q  <= '0;
				digit_low_q   <= '0;
			end else if (c != CH_CR && in_sentence_q) begin
				if (c == CH_LF) begin
					in_sentence_q <= 1'b0;
				end else begin
					if (c == CH_STAR)
						past_star_q <= 1'b1;
					else if (!past_star_q)
						xor_q <= xor_q ^ c;
					// Store while below capacity
					if (stored_cnt_q < STORE_LIMIT) begin
						if (stored_cnt_q < 8'(HEADER_LEN))
							header_q[stored_cnt_q[2:0]] <= c;
						if (star_stored_q) begin
							if (digits_q == 2'd0) begin
								digit_high_q <= c;
								digits_q     <= 2'd1;
							end else if (digits_q == 2'd1) begin
								digit_low_q <= c;
								digits_q    <= 2'd2;
							end
						end else if (c == CH_STAR) begin
							star_stored_q <= 1'b1;
						end
						stored_cnt_q <= stored_cnt_q + 8'd1;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/nscc_queue.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum checker close-record queue
// Small FIFO decoupling the byte front end from the result back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nmea_sentence_checksum_checker_unit_assert.svh"

module nscc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nscc_pkg::close_t push_rec,
	output logic             full,
	input  logic             pop,
	output nscc_pkg::close_t pop_rec,
	output logic             empty
);
	import nscc_pkg::*;

	close_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_rec = slot_q[rd_ptr_q];

	// Storage write
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_rec;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`NSCC_ASSERT_NOW(a_no_push_full, full, !push, "queue pushed while full")
	`NSCC_ASSERT_NOW(a_no_pop_empty, empty, !pop, "queue popped while empty")
	`NSCC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue overfilled")

endmodule

// ===== rtl/nscc_back.sv =====
// ---------------------------------------------------------------------------
// NMEA checksum checker back end
// Decodes the received checksum, compares, classifies the header, keeps the
// pass and fail counts and holds the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nmea_sentence_checksum_checker_unit_assert.svh"

module nscc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  nscc_pkg::close_t pop_rec,
	output logic             pop,
	nscc_result_if.source    res
);
	import nscc_pkg::*;

	logic        res_valid_q;
	logic [1:0]  outcome_q;
	logic [2:0]  kind_q;
	logic        accepted_q;
	logic [7:0]  computed_q;
	logic [7:0]  received_q;
	logic [31:0] pass_q;
	logic [31:0] fail_q;
	logic [31:0] bytes_q;

	logic [7:0] hex_hi;
	logic [7:0] hex_lo;
	logic [7:0] received;
	logic       match;
	logic [1:0] outcome;
	logic [2:0] kind;

	// Take a record whenever the result register is free or being drained
	assign pop = !empty && (!res_valid_q || res.ready);

	// Checksum decode and compare
	always_comb begin
		hex_hi   = hex_value(pop_rec.digit_high);
		hex_lo   = hex_value(pop_rec.digit_low);
		received = pop_rec.asterisk_stored ? ({hex_hi[3:0], 4'h0} + hex_lo) : 8'h00;
		match    = (received == pop_rec.running_xor);
		if (!pop_rec.asterisk_stored)
			outcome = OUT_NO_STAR;
		else if (match)
			outcome = OUT_MATCH;
		else
			outcome = OUT_MISMATCH;
		kind = (outcome == OUT_MATCH) ? classify(pop_rec.header) : KIND_UNKNOWN;
	end

	// Result valid and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pass_q      <= '0;
			fail_q      <= '0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
				if (outcome == OUT_MATCH)
					pass_q <= pass_q + 32'd1;
				else if (outcome == OUT_MISMATCH)
					fail_q <= fail_q + 32'd1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			outcome_q  <= outcome;
			kind_q     <= kind;
			accepted_q <= (outcome == OUT_MATCH) && (kind != KIND_UNKNOWN);
			computed_q <= pop_rec.running_xor;
			received_q <= received;
			bytes_q    <= pop_rec.byte_total;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.outcome       = outcome_q;
	assign res.sentence_kind = kind_q;
	assign res.accepted      = accepted_q;
	assign res.computed_sum  = computed_q;
	assign res.received_sum  = received_q;
	assign res.pass_total    = pass_q;
	assign res.fail_total    = fail_q;
	assign res.byte_total    = bytes_q;

	`NSCC_ASSERT_NOW(a_outcome_legal, res_valid_q, outcome_q != 2'd3, "illegal outcome code")
	`NSCC_ASSERT_NOW(a_accept_match, res_valid_q && accepted_q, (outcome_q == OUT_MATCH) && (kind_q != KIND_UNKNOWN), "accepted without known matching sentence")
	`NSCC_ASSERT_NEXT(a_pass_step, pop && (outcome == OUT_MATCH), pass_q == $past(pass_q) + 32'd1, "pass count did not advance")
	`NSCC_ASSERT_NEXT(a_fail_step, pop && (outcome == OUT_MISMATCH), fail_q == $past(fail_q) + 32'd1, "fail count did not advance")

endmodule

// ===== rtl/nmea_sentence_checksum_checker_unit.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checksum checker
// Checks NMEA 0183 sentences byte by byte and reports one result per sentence.
// ---------------------------------------------------------------------------
// Usage:
//   rx  : valid/ready byte channel, one received character per item.
//   res : valid/ready result channel, one item per sentence closed by a
//         line feed (outcome, kind, sums and the three running totals).
//   Throughput: one byte per cycle. rx.ready drops only when the four-entry
//   close-record queue is full, which happens only after several line feeds
//   arrive while res is stalled.
//   Result path: the close record of a closing line feed is written into the
//   queue, and the result register takes it from there once it is free.
//   Bytes other than line feed never produce a result.
//   Stall: while res.ready is low the result register holds; later closes
//   wait in the queue and byte intake carries on until the queue fills.
//   Reset (arst_n low, asynchronous): no sentence open, queue empty, result
//   channel idle, pass, fail and byte counts zero. Bytes are accepted as soon as reset ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_checksum_checker_unit (
	input  logic          clk,
	input  logic          arst_n,
	nscc_byte_if.sink     rx,
	nscc_result_if.source res
);
	import nscc_pkg::*;

	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;
	close_t push_rec;
	close_t pop_rec;

	// Byte intake and sentence tracking
	nscc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	// Close-record queue
	nscc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (q_empty)
	);

	// Checksum verdict and result register
	nscc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.pop_rec (pop_rec),
		.pop     (pop),
		.res     (res)
	);

endmodule

// ===== tb/tb_nmea_sentence_checksum_checker_unit.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checksum checker testbench
// Drives received bytes through the byte channel and checks every sentence
// result against a cycle-free software tracker of the checker. A short table
// of hand-made lines comes first, then random sentences, broken lines and
// line noise. The byte channel idles and the result channel stalls at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nmea_sentence_checksum_checker_unit;
	import nscc_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP    = 50;

	typedef enum logic [2:0] {
		SK_UNKNOWN, SK_GNGGA, SK_GNRMC, SK_GNGSA, SK_GLGSV, SK_GPGSV, SK_BDGSV, SK_GNVTG
	} kind_e;

	typedef logic [7:0] octet_q_t [$];

	// One sentence result
	typedef struct {
		logic [1:0]  outcome;
		logic [2:0]  kind;
		logic        accepted;
		logic [7:0]  computed;
		logic [7:0]  received;
		logic [31:0] passes;
		logic [31:0] fails;
		logic [31:0] total_bytes;
	} report_t;

	// Hand-made line; t_recv < 0 leaves the received sum to the tracker
	typedef struct {
		string      text;
		int         zpos;
		bit         seal;
		bit         lower;
		bit         typed;
		logic [1:0] t_out;
		kind_e      t_kind;
		int         t_recv;
	} line_row_t;

	logic clk;
	logic arst_n;

	nscc_byte_if   rx_ch ();
	nscc_result_if res_ch ();

	nmea_sentence_checksum_checker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	// Sentence headers in kind order, first character in the top byte
	logic [39:0] kind_tags [7] = '{"GNGGA", "GNRMC", "GNGSA", "GLGSV", "GPGSV", "BDGSV", "GNVTG"};

	// Tracker state
	bit          open_sentence;
	bit          xor_stopped;
	logic [7:0]  xor_acc;
	logic [7:0]  n_stored;
	logic [39:0] hdr;
	bit          star_seen;
	logic [1:0]  n_digits;
	logic [7:0]  dig_hi;
	logic [7:0]  dig_lo;
	logic [31:0] n_pass;
	logic [31:0] n_fail;
	logic [31:0] n_bytes;

	report_t   awaited_reports [$];
	line_row_t line_table [$];
	int        n_errors;
	int        idle_cycles;
	bit        calm;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		if (c >= "A" && c <= "F")
			return c - "A" + 8'd10;
		if (c >= "a" && c <= "f")
			return c - "a" + 8'd10;
		return c - 8'd48;
	endfunction

	function automatic kind_e kind_of_header(input logic [39:0] h);
		kind_e found;
		found = SK_UNKNOWN;
		for (int k = 0; k < 7; k++)
			if (found == SK_UNKNOWN && h == kind_tags[k])
				found = kind_e'(k + 1);
		return found;
	endfunction

	function automatic void clear_sentence();
		xor_stopped = 0;
		xor_acc = '0;
		n_stored = '0;
		hdr = '0;
		star_seen = 0;
		n_digits = '0;
		dig_hi = '0;
		dig_lo = '0;
	endfunction

	// Advance the tracker by one accepted byte; a closing line feed queues a report
	function automatic bit follow_byte(input logic [7:0] c);
		report_t r;
		kind_e   k;
		n_bytes++;
		if (c == CH_DOLLAR) begin
			clear_sentence();
			open_sentence = 1;
			return 0;
		end
		if (c == CH_CR || !open_sentence)
			return 0;
		if (c != CH_LF) begin
			if (c == CH_STAR)
				xor_stopped = 1;
			if (!xor_stopped)
				xor_acc ^= c;
			if (n_stored < STORE_LIMIT) begin
				if (n_stored < 5)
					hdr[8*(4-n_stored) +: 8] = c;
				if (star_seen) begin
					if (n_digits == 0) begin
						dig_hi = c;
						n_digits = 1;
					end else if (n_digits == 1) begin
						dig_lo = c;
						n_digits = 2;
					end
				end else if (c == CH_STAR) begin
					star_seen = 1;
				end
				n_stored++;
			end
			return 0;
		end
		// Line feed closes the sentence
		open_sentence = 0;
		r.outcome = OUT_NO_STAR;
		r.received = '0;
		k = SK_UNKNOWN;
		if (star_seen) begin
			r.received = 8'(16 * digit_value(dig_hi) + digit_value(dig_lo));
			if (r.received != xor_acc) begin
				n_fail++;
				r.outcome = OUT_MISMATCH;
			end else begin
				n_pass++;
				r.outcome = OUT_MATCH;
				k = kind_of_header(hdr);
			end
		end
		r.kind = k;
		r.accepted = (r.outcome == OUT_MATCH && k != SK_UNKNOWN);
		r.computed = xor_acc;
		r.passes = n_pass;
		r.fails = n_fail;
		r.total_bytes = n_bytes;
		awaited_reports.push_back(r);
		return 1;
	endfunction

	// Gap length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		if ($urandom_range(0, 29) == 0)
			c = 8'($urandom_range(0, 255));
		else
			c = 8'($urandom_range(32, 126));
		if (c == CH_DOLLAR || c == CH_STAR || c == CH_LF)
			c = ",";
		return c;
	endfunction

	function automatic void add_row(string text, int zpos, bit seal, bit lower, bit typed,
			logic [1:0] t_out, kind_e t_kind, int t_recv);
		line_row_t row;
		row.text = text;
		row.zpos = zpos;
		row.seal = seal;
		row.lower = lower;
		row.typed = typed;
		row.t_out = t_out;
		row.t_kind = t_kind;
		row.t_recv = t_recv;
		line_table.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_errors < PRINT_CAP)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		n_errors++;
	endtask

	// Offer one byte until accepted, then update the tracker
	task automatic send_byte(input logic [7:0] c, output bit closed);
		rx_ch.rx_byte <= c;
		rx_ch.valid <= 1'b1;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		closed = follow_byte(c);
	endtask

	// Send a line; idling falls before each byte so nothing passes after the last
	task automatic transmit(input octet_q_t chars, output bit closed);
		int g;
		bit c_last;
		closed = 0;
		foreach (chars[i]) begin
			g = calm ? 0 : idle_len();
			if (g > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			send_byte(chars[i], c_last);
			closed = c_last;
		end
	endtask

	// Hold the sender until every awaited report has come
	task automatic drain();
		rx_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_reports.size() != 0);
	endtask

	// Expand a table row, appending a correct checksum when sealed
	function automatic octet_q_t row_bytes(input line_row_t row);
		octet_q_t   chars;
		logic [7:0] sum;
		logic [7:0] c;
		string      hx;
		sum = '0;
		for (int i = 0; i < row.text.len(); i++) begin
			c = (i == row.zpos) ? 8'h00 : row.text[i];
			chars.push_back(c);
			if (c == CH_DOLLAR)
				sum = '0;
			else if (c != CH_CR)
				sum ^= c;
		end
		if (row.seal) begin
			hx = row.lower ? $sformatf("%02x", sum) : $sformatf("%02X", sum);
			chars.push_back(CH_STAR);
			chars.push_back(hx[0]);
			chars.push_back(hx[1]);
			chars.push_back(CH_CR);
			chars.push_back(CH_LF);
		end
		return chars;
	endfunction

	// Random line: mostly well formed, the rest broken lines and noise
	function automatic octet_q_t random_line();
		octet_q_t    chars;
		logic [39:0] tag;
		logic [7:0]  sum;
		string       hx;
		int          r;
		int          d;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			chars.push_back(CH_DOLLAR);
			if ($urandom_range(0, 9) < 7) begin
				tag = kind_tags[$urandom_range(0, 6)];
				for (int i = 0; i < 5; i++)
					chars.push_back(tag[8*(4-i) +: 8]);
			end else begin
				repeat ($urandom_range(0, 6)) chars.push_back(8'($urandom_range(65, 90)));
			end
			// a few long lines run past the storage capacity
			repeat (($urandom_range(0, 19) == 0) ? $urandom_range(110, 130) :
					$urandom_range(0, 20))
				chars.push_back(field_char());
			sum = '0;
			foreach (chars[i])
				if (i > 0 && chars[i] != CH_CR)
					sum ^= chars[i];
			if ($urandom_range(0, 9) != 0) begin
				chars.push_back(CH_STAR);
				d = $urandom_range(0, 9);
				if (d < 8) begin
					if (d == 7)
						sum ^= 8'(1 << $urandom_range(0, 7));
					hx = (d == 6) ? $sformatf("%02x", sum) : $sformatf("%02X", sum);
					chars.push_back(hx[0]);
					chars.push_back(hx[1]);
				end else begin
					repeat ($urandom_range(0, 2)) chars.push_back(field_char());
				end
			end
			if ($urandom_range(0, 1))
				chars.push_back(CH_CR);
			chars.push_back(CH_LF);
		end else if (r < 88) begin
			// unterminated line; later bytes run on in it until a dollar or line feed
			chars.push_back(CH_DOLLAR);
			repeat ($urandom_range(0, 10)) chars.push_back(field_char());
			if ($urandom_range(0, 1))
				chars.push_back(CH_STAR);
		end else begin
			repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
		end
		return chars;
	endfunction

	// Result checker
	always @(posedge clk) begin
		report_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_reports.size() == 0) begin
				report_mismatch("unexpected result", res_ch.byte_total, 32'h0);
			end else begin
				want = awaited_reports.pop_front();
				if (res_ch.outcome !== want.outcome)
					report_mismatch("outcome", res_ch.outcome, want.outcome);
				if (res_ch.sentence_kind !== want.kind)
					report_mismatch("sentence_kind", res_ch.sentence_kind, want.kind);
				if (res_ch.accepted !== want.accepted)
					report_mismatch("accepted", res_ch.accepted, want.accepted);
				if (res_ch.computed_sum !== want.computed)
					report_mismatch("computed_sum", res_ch.computed_sum, want.computed);
				if (res_ch.received_sum !== want.received)
					report_mismatch("received_sum", res_ch.received_sum, want.received);
				if (res_ch.pass_total !== want.passes)
					report_mismatch("pass_total", res_ch.pass_total, want.passes);
				if (res_ch.fail_total !== want.fails)
					report_mismatch("fail_total", res_ch.fail_total, want.fails);
				if (res_ch.byte_total !== want.total_bytes)
					report_mismatch("byte_total", res_ch.byte_total, want.total_bytes);
			end
		end
	end

	// Result side back-pressure: alternating ready and stall phases
	initial begin
		int  ready_hold;
		bit  ready_now;
		ready_hold = 0;
		ready_now = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (ready_hold == 0) begin
				ready_now = !ready_now;
				if (ready_now)
					ready_hold = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200) :
						$urandom_range(1, 6);
				else
					ready_hold = 1 + idle_len();
			end
			ready_hold--;
			res_ch.ready <= ready_now;
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[nmea_sentence_checksum_checker_unit] ERROR");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		octet_q_t chars;
		string    fill;
		bit       closed;
		int       n_random;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		arst_n <= 1'b0;
		n_errors = 0;
		n_random = 0;
		open_sentence = 0;
		clear_sentence();
		n_pass = '0;
		n_fail = '0;
		n_bytes = '0;

		// text, zero position, seal, lower-case digits, typed, outcome, kind, received
		add_row("\n", -1, 0, 0, 0, OUT_NO_STAR, SK_UNKNOWN, -1);
		add_row("xyz\r\377\n", -1, 0, 0, 0, OUT_NO_STAR, SK_UNKNOWN, -1);
		add_row("$GNGGA,1", -1, 1, 0, 1, OUT_MATCH, SK_GNGGA, -1);
		add_row("$GNRMC,A", -1, 1, 0, 1, OUT_MATCH, SK_GNRMC, -1);
		add_row("$GNGSA,,", -1, 1, 0, 1, OUT_MATCH, SK_GNGSA, -1);
		add_row("$GLGSV", -1, 1, 1, 1, OUT_MATCH, SK_GLGSV, -1);
		add_row("$GPGSV,3", -1, 1, 0, 1, OUT_MATCH, SK_GPGSV, -1);
		add_row("$BDGSV", -1, 1, 1, 1, OUT_MATCH, SK_BDGSV, -1);
		add_row("$GNVTG,~", -1, 1, 0, 1, OUT_MATCH, SK_GNVTG, -1);
		// short header, restart on a second dollar, code zero inside the header
		add_row("$GN,Z", -1, 1, 0, 1, OUT_MATCH, SK_UNKNOWN, -1);
		add_row("$GPGGA,5$GNRMC", -1, 1, 0, 1, OUT_MATCH, SK_GNRMC, -1);
		add_row("$GN?GA", 3, 1, 0, 1, OUT_MATCH, SK_UNKNOWN, -1);
		add_row("$\377\200abc", -1, 1, 0, 1, OUT_MATCH, SK_UNKNOWN, -1);
		// digit decoding: missing digits, non-hex codes, case edges
		add_row("$\n", -1, 0, 0, 1, OUT_NO_STAR, SK_UNKNOWN, 'h00);
		add_row("$*\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'hD0);
		add_row("$\r*00\r\n", -1, 0, 0, 1, OUT_MATCH, SK_UNKNOWN, 'h00);
		add_row("$*ff\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'hFF);
		add_row("$*FF\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'hFF);
		add_row("$*Aa\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'hAA);
		add_row("$*G/\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'h6F);
		add_row("$*@g\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'h37);
		add_row("$A*1\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'hE0);
		add_row("$**12\n", -1, 0, 0, 1, OUT_MISMATCH, SK_UNKNOWN, 'hA1);
		// capacity: asterisk beyond the store, then low digit beyond the store
		fill = "";
		repeat (126) fill = {fill, ","};
		add_row({"$GNGGA", fill}, -1, 1, 0, 1, OUT_NO_STAR, SK_UNKNOWN, 'h00);
		fill = "";
		repeat (120) fill = {fill, ","};
		add_row({"$GNGGA", fill}, -1, 1, 0, 0, OUT_NO_STAR, SK_UNKNOWN, -1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines; typed fields override the tracker's values
		foreach (line_table[i]) begin
			calm = ($urandom_range(0, 2) == 0);
			chars = row_bytes(line_table[i]);
			transmit(chars, closed);
			if (closed && line_table[i].typed) begin
				awaited_reports[awaited_reports.size()-1].outcome = line_table[i].t_out;
				awaited_reports[awaited_reports.size()-1].kind = line_table[i].t_kind;
				awaited_reports[awaited_reports.size()-1].accepted =
					(line_table[i].t_out == OUT_MATCH && line_table[i].t_kind != SK_UNKNOWN);
				if (line_table[i].t_recv >= 0)
					awaited_reports[awaited_reports.size()-1].received =
						8'(line_table[i].t_recv);
			end
		end
		drain();

		// Random lines with an occasional full drain
		while (n_random < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			chars = random_line();
			n_random += chars.size();
			transmit(chars, closed);
			if ($urandom_range(0, 29) == 0)
				drain();
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0 && awaited_reports.size() == 0)
			$display("[nmea_sentence_checksum_checker_unit] OK");
		else
			$display("[nmea_sentence_checksum_checker_unit] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nscc_pkg.sv
rtl/nscc_if.sv
rtl/nscc_front.sv
rtl/nscc_queue.sv
rtl/nscc_back.sv
rtl/nmea_sentence_checksum_checker_unit.sv
tb/tb_nmea_sentence_checksum_checker_unit.sv
